// ===== sv/kmer_code_scanner_unit_defines.svh =====
// Assertion macros shared by the checker.
`ifndef KMER_CODE_SCANNER_UNIT_DEFINES_SVH
`define KMER_CODE_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define KCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcs check failed");

// next-cycle implication, off during reset
`define KCS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcs check failed");

// state right after a reset cycle
`define KCS_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("kcs reset check failed");

`endif

// ===== sv/kcs_pkg.sv =====
`default_nettype none

package kcs_pkg;

  localparam int unsigned CODE_W = 64;
  localparam int unsigned SEQ_W  = 20;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned LEN_W  = 25;
  localparam int unsigned K_W    = 6;
  localparam int unsigned NSEQ_W = 21;
  localparam int unsigned CFG_W  = 25;
  localparam int unsigned IDX_W  = 2;

  localparam logic [32:0]    MAX_SEGMENT_LEN = 33'd16777216;
  localparam logic [K_W-1:0] MAX_KMER        = 6'd32;

  localparam logic [IDX_W-1:0] CFG_KMER_SIZE = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MIN_MATCH = 2'd1;
  localparam logic [IDX_W-1:0] CFG_NUM_SEQS  = 2'd2;

  localparam logic [K_W-1:0]    RST_KMER_SIZE = 6'd32;
  localparam logic [LEN_W-1:0]  RST_MIN_MATCH = 25'd32;
  localparam logic [NSEQ_W-1:0] RST_NUM_SEQS  = 21'd1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  typedef struct packed {
    logic [K_W-1:0]    kmer_size;
    logic [LEN_W-1:0]  min_match;
    logic [NSEQ_W-1:0] num_seqs;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SEQ_W-1:0]  result_seq;
    logic [POS_W-1:0]  rel_pos;
    logic              is_reverse;
    logic              last;
  } res_t;

  typedef struct packed {
    logic push0;
    logic push1;
    res_t w0;
    res_t w1;
  } push_t;

endpackage

`default_nettype wire

// ===== sv/kcs_kmer_core.sv =====
`default_nettype none

module kcs_kmer_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       acc,
  input  wire kcs_pkg::cfg_t              cfg,
  input  wire logic [1:0]                 base,
  input  wire logic                       segment_start,
  input  wire logic [kcs_pkg::LEN_W-1:0]  segment_length,
  input  wire logic [kcs_pkg::SEQ_W-1:0]  seq_number,
  output kcs_pkg::push_t                  push
);

  logic [kcs_pkg::CODE_W-1:0] fwd_r, fwd_nxt, rev_r, rev_nxt;
  logic [kcs_pkg::LEN_W-1:0]  seen_r, seen_nxt;

  logic [kcs_pkg::K_W-1:0]    k_eff;
  logic [6:0]                 two_k;
  logic [kcs_pkg::CODE_W-1:0] mask, ins, fwd_base, rev_base;
  logic [kcs_pkg::LEN_W-1:0]  idx;
  logic [1:0]                 nb;
  logic [25:0]                i1, k26, len26, mm26, p, lastp, limit, q;
  logic                       ok, fwd_go, rev_go;
  logic [kcs_pkg::NSEQ_W-1:0] rseq;
  kcs_pkg::res_t              fwd_w, rev_w;

  always_comb begin
    priority if (cfg.kmer_size == '0) begin
      k_eff = 6'd1;
    end else if (cfg.kmer_size > kcs_pkg::MAX_KMER) begin
      k_eff = kcs_pkg::MAX_KMER;
    end else begin
      k_eff = cfg.kmer_size;
    end
  end

  assign two_k = {k_eff, 1'b0};
  assign nb    = base ^ 2'b11;

  always_comb begin
    for (int j = 0; j < kcs_pkg::CODE_W; j++) begin
      mask[j] = (7'(j) < two_k);
      if (7'(j) == two_k - 7'd2) begin
        ins[j] = nb[0];
      end else if (7'(j) == two_k - 7'd1) begin
        ins[j] = nb[1];
      end else begin
        ins[j] = 1'b0;
      end
    end
  end

  assign fwd_base = segment_start ? '0 : fwd_r;
  assign rev_base = segment_start ? '0 : rev_r;
  assign idx      = segment_start ? '0 : seen_r;

  assign fwd_nxt  = ({fwd_base[kcs_pkg::CODE_W-3:0], base}) & mask;
  assign rev_nxt  = ({2'b00, rev_base[kcs_pkg::CODE_W-1:2]} | ins) & mask;
  assign seen_nxt = (idx != '1) ? idx + 25'd1 : idx;

  assign i1    = {1'b0, idx} + 26'd1;
  assign k26   = {20'd0, k_eff};
  assign len26 = {1'b0, segment_length};
  assign mm26  = {1'b0, cfg.min_match};

  assign ok = ({8'd0, segment_length} <= kcs_pkg::MAX_SEGMENT_LEN) &&
              (len26 >= mm26) && (len26 >= k26) &&
              ({1'b0, idx} < len26) && (i1 >= k26);

  assign p      = i1 - k26;
  assign lastp  = len26 - k26;
  assign limit  = len26 - mm26;
  assign q      = lastp - p;
  assign fwd_go = acc && ok && (p <= lastp) && (p <= limit);
  assign rev_go = acc && ok && (p <= lastp) && (q <= limit);

  assign rseq = cfg.num_seqs - 21'd1 - {1'b0, seq_number};

  always_comb begin
    fwd_w.code       = fwd_nxt;
    fwd_w.result_seq = seq_number;
    fwd_w.rel_pos    = p[kcs_pkg::POS_W-1:0];
    fwd_w.is_reverse = 1'b0;
    fwd_w.last       = !rev_go;
    rev_w.code       = rev_nxt;
    rev_w.result_seq = rseq[kcs_pkg::SEQ_W-1:0];
    rev_w.rel_pos    = q[kcs_pkg::POS_W-1:0];
    rev_w.is_reverse = 1'b1;
    rev_w.last       = 1'b1;
    push.push0       = fwd_go || rev_go;
    push.push1       = fwd_go && rev_go;
    push.w0          = fwd_go ? fwd_w : rev_w;
    push.w1          = rev_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      rev_r  <= '0;
      seen_r <= '0;
    end else if (acc) begin
      fwd_r  <= fwd_nxt;
      rev_r  <= rev_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kcs_result_fifo.sv =====
`default_nettype none

module kcs_result_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire kcs_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output kcs_pkg::res_t       out_word
);

  kcs_pkg::res_t                mem [kcs_pkg::FIFO_DEPTH];
  logic [kcs_pkg::FIFO_AW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [kcs_pkg::FIFO_CW-1:0]  cnt_r, cnt_nxt, n_push;
  logic                         pop;

  assign room      = cnt_r <= kcs_pkg::FIFO_CW'(kcs_pkg::FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_word  = mem[rd_r];
  assign pop       = out_valid && out_ready;

  assign n_push  = {1'b0, push.push1, push.push0 && !push.push1};
  assign wr_nxt  = wr_r + n_push[kcs_pkg::FIFO_AW-1:0];
  assign rd_nxt  = rd_r + kcs_pkg::FIFO_AW'(pop);
  assign cnt_nxt = cnt_r + n_push - kcs_pkg::FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_r] <= push.w0;
    end
    if (push.push1) begin
      mem[wr_r + kcs_pkg::FIFO_AW'(1)] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kmer_code_scanner_unit.sv =====
// Channel | Direction | Handshake           | Word
// cfg     | in        | cfg_we              | cfg_index, cfg_wdata
// in      | in        | in_valid / in_ready | base, segment start, length, seq number
// out     | out       | out_valid/out_ready | code, seq, rel_pos, is_reverse, last
//
// One base word per cycle while in_ready; each gives zero, one or two result words.
// A result word is in the queue the cycle after its base is taken.
// Output drains one word per cycle while out_ready is high; reset is synchronous.
// in_ready drops while fewer than two queue slots are free.
// Reset clears codes, counter, queue and loads config defaults; no clearing pass.
`default_nettype none

module kmer_code_scanner_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [kcs_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [kcs_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_base,
  input  wire logic                        in_segment_start,
  input  wire logic [kcs_pkg::LEN_W-1:0]   in_segment_length,
  input  wire logic [kcs_pkg::SEQ_W-1:0]   in_seq_number,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [kcs_pkg::CODE_W-1:0]       out_code,
  output logic [kcs_pkg::SEQ_W-1:0]        out_result_seq,
  output logic [kcs_pkg::POS_W-1:0]        out_rel_pos,
  output logic                             out_is_reverse,
  output logic                             out_last
);

  kcs_pkg::cfg_t  cfg_r;
  kcs_pkg::push_t push;
  kcs_pkg::res_t  word;
  logic           room, acc;

  assign in_ready = room;
  assign acc      = in_valid && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kmer_size <= kcs_pkg::RST_KMER_SIZE;
      cfg_r.min_match <= kcs_pkg::RST_MIN_MATCH;
      cfg_r.num_seqs  <= kcs_pkg::RST_NUM_SEQS;
    end else if (cfg_we) begin
      if (cfg_index == kcs_pkg::CFG_KMER_SIZE) begin
        cfg_r.kmer_size <= cfg_wdata[kcs_pkg::K_W-1:0];
      end
      if (cfg_index == kcs_pkg::CFG_MIN_MATCH) begin
        cfg_r.min_match <= cfg_wdata[kcs_pkg::LEN_W-1:0];
      end
      if (cfg_index == kcs_pkg::CFG_NUM_SEQS) begin
        cfg_r.num_seqs <= cfg_wdata[kcs_pkg::NSEQ_W-1:0];
      end
    end
  end

  kcs_kmer_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .cfg            (cfg_r),
    .base           (in_base),
    .segment_start  (in_segment_start),
    .segment_length (in_segment_length),
    .seq_number     (in_seq_number),
    .push           (push)
  );

  kcs_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (word)
  );

  assign out_code       = word.code;
  assign out_result_seq = word.result_seq;
  assign out_rel_pos    = word.rel_pos;
  assign out_is_reverse = word.is_reverse;
  assign out_last       = word.last;

endmodule

`default_nettype wire

// ===== sv/kcs_checker.sv =====
`default_nettype none
`include "kmer_code_scanner_unit_defines.svh"

module kcs_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [kcs_pkg::CODE_W-1:0]    out_code,
  input wire logic                          out_is_reverse,
  input wire logic                          out_last
);

  `KCS_ASSERT_RST(a_reset_idle, !out_valid && in_ready)
  `KCS_ASSERT_IMP(a_first_is_fwd, out_valid && !out_last, !out_is_reverse)
  `KCS_ASSERT_NXT(a_pair_follows, out_valid && out_ready && !out_last,
                  out_valid && out_is_reverse && out_last)
  `KCS_ASSERT_NXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(out_code))

endmodule

bind kmer_code_scanner_unit kcs_checker u_kcs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_code       (out_code),
  .out_is_reverse (out_is_reverse),
  .out_last       (out_last)
);

`default_nettype wire

// ===== tb/tb_kmer_code_scanner_unit.sv =====
`default_nettype none

package kmer_scan_tb_pkg;
  import kcs_pkg::*;

  class kmer_scoreboard;
    logic [K_W-1:0]    kmer_size;
    logic [LEN_W-1:0]  min_match;
    logic [NSEQ_W-1:0] num_seqs;
    logic [63:0]       fwd_code;
    logic [63:0]       rc_code;
    logic [LEN_W-1:0]  bases_seen;
    res_t              expected_words[$];
    int                mismatches;
    int                words_checked;
    int                fwd_words;
    int                rc_words;

    function new();
      kmer_size = RST_KMER_SIZE;
      min_match = RST_MIN_MATCH;
      num_seqs = RST_NUM_SEQS;
      fwd_code = '0;
      rc_code = '0;
      bases_seen = '0;
      mismatches = 0;
      words_checked = 0;
      fwd_words = 0;
      rc_words = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_KMER_SIZE: kmer_size = data[K_W-1:0];
        CFG_MIN_MATCH: min_match = data[LEN_W-1:0];
        CFG_NUM_SEQS:  num_seqs = data[NSEQ_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // roll both codes and queue the k-mer words this base ends
    function void note_base(logic [1:0] b, logic seg_start, logic [LEN_W-1:0] len,
                            logic [SEQ_W-1:0] seq);
      logic [63:0] k;
      logic [63:0] mask;
      logic [63:0] idx;
      logic [63:0] len64;
      logic [63:0] p;
      logic [63:0] lastp;
      logic [63:0] lim;
      logic [63:0] q;
      logic [63:0] mirror;
      res_t        fw;
      res_t        rw;
      bit          have_fw;
      bit          have_rw;
      k = 64'(kmer_size);
      if (k < 64'd1) k = 64'd1;
      if (k > 64'(MAX_KMER)) k = 64'(MAX_KMER);
      mask = (k >= 64'd32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
      if (seg_start) begin
        bases_seen = '0;
        fwd_code = '0;
        rc_code = '0;
      end
      fwd_code = ((fwd_code << 2) | 64'(b)) & mask;
      rc_code = ((rc_code >> 2) | (64'(b ^ 2'd3) << (2 * (k - 64'd1)))) & mask;
      idx = 64'(bases_seen);
      if (bases_seen != '1) bases_seen = bases_seen + 1'b1;
      len64 = 64'(len);
      if (len64 > 64'(MAX_SEGMENT_LEN) || len64 < 64'(min_match) || len64 < k) return;
      if (idx >= len64 || idx + 64'd1 < k) return;
      p = idx + 64'd1 - k;
      lastp = len64 - k;
      lim = len64 - 64'(min_match);
      if (p > lastp) return;
      q = lastp - p;
      have_fw = (p <= lim);
      have_rw = (q <= lim);
      mirror = 64'(num_seqs) - 64'd1 - 64'(seq);
      fw = '{code: fwd_code, result_seq: seq, rel_pos: p[POS_W-1:0],
             is_reverse: 1'b0, last: !have_rw};
      rw = '{code: rc_code, result_seq: mirror[SEQ_W-1:0], rel_pos: q[POS_W-1:0],
             is_reverse: 1'b1, last: 1'b1};
      if (have_fw) expected_words.push_back(fw);
      if (have_rw) expected_words.push_back(rw);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch at result word %0d: %s got %0h want %0h",
                 words_checked, what, got, want);
    endtask

    task check_word(res_t got);
      res_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, code", got.code, 64'd0);
        return;
      end
      want = expected_words.pop_front();
      if (want.is_reverse) rc_words++;
      else fwd_words++;
      if (got.code !== want.code) report_mismatch("code", got.code, want.code);
      if (got.result_seq !== want.result_seq)
        report_mismatch("result_seq", 64'(got.result_seq), 64'(want.result_seq));
      if (got.rel_pos !== want.rel_pos)
        report_mismatch("rel_pos", 64'(got.rel_pos), 64'(want.rel_pos));
      if (got.is_reverse !== want.is_reverse)
        report_mismatch("is_reverse", 64'(got.is_reverse), 64'(want.is_reverse));
      if (got.last !== want.last)
        report_mismatch("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

endpackage

module tb_kmer_code_scanner_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import kcs_pkg::*;
  import kmer_scan_tb_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [LEN_W-1:0] LEN_ALL_ONES = '1;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_base;
  logic              in_segment_start;
  logic [LEN_W-1:0]  in_segment_length;
  logic [SEQ_W-1:0]  in_seq_number;
  logic              out_valid;
  logic              out_ready;
  logic [CODE_W-1:0] out_code;
  logic [SEQ_W-1:0]  out_result_seq;
  logic [POS_W-1:0]  out_rel_pos;
  logic              out_is_reverse;
  logic              out_last;

  kmer_scoreboard sb;
  int             cycles = 0;
  int             words_sent = 0;
  int             settings_used = 0;
  int             burst_left = 0;
  int             holds_done = 0;
  bit             hold_req = 1'b0;
  int             k_eff = 32;
  int             cur_mm = 32;
  logic [LEN_W-1:0] cur_len = 25'd1;
  logic [SEQ_W-1:0] cur_seq = '0;

  kmer_code_scanner_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_base(in_base),
    .in_segment_start(in_segment_start),
    .in_segment_length(in_segment_length),
    .in_seq_number(in_seq_number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_code(out_code),
    .out_result_seq(out_result_seq),
    .out_rel_pos(out_rel_pos),
    .out_is_reverse(out_is_reverse),
    .out_last(out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word({out_code, out_result_seq, out_rel_pos, out_is_reverse, out_last});
  end

  initial begin
    logic [7:0] rx_mask;
    int         rx_phase;
    out_ready = 1'b0;
    rx_mask = '1;
    rx_phase = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (rx_phase == 0) begin
          case ($urandom_range(0, 3))
            0: rx_mask = '1;
            1: rx_mask = 8'($urandom) | 8'd1;
            2: rx_mask = 8'b0000_0001;
            default: rx_mask = 8'($urandom);
          endcase
          if (rx_mask == '0) rx_mask = 8'b1000_0000;
        end
        out_ready = rx_mask[rx_phase % 8];
        rx_phase = (rx_phase + 1) % 64;
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [K_W-1:0] k, input logic [LEN_W-1:0] mm,
                               input logic [NSEQ_W-1:0] nseq);
    write_reg(CFG_KMER_SIZE, CFG_W'(k));
    write_reg(CFG_MIN_MATCH, CFG_W'(mm));
    write_reg(CFG_NUM_SEQS, CFG_W'(nseq));
    k_eff = (k == 0) ? 1 : ((k > MAX_KMER) ? int'(MAX_KMER) : int'(k));
    cur_mm = int'(mm);
    settings_used++;
  endtask

  // bursts of random length, then a random gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic send_word(input logic [1:0] b, input logic st,
                           input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] sq);
    @(negedge clk);
    in_valid = 1'b1;
    in_base = b;
    in_segment_start = st;
    in_segment_length = len;
    in_seq_number = sq;
    do @(posedge clk); while (!in_ready);
    sb.note_base(b, st, len, sq);
    words_sent++;
    pace();
  endtask

  task automatic send_segment(input logic [LEN_W-1:0] len, input int nb,
                              input logic [SEQ_W-1:0] sq, input bit with_start);
    cur_len = len;
    cur_seq = sq;
    for (int j = 0; j < nb; j++)
      send_word(2'($urandom_range(0, 3)), with_start && (j == 0), len, sq);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] clamp_len(longint unsigned v);
    return (v > longint'(LEN_ALL_ONES)) ? LEN_ALL_ONES : LEN_W'(v);
  endfunction

  function automatic logic [SEQ_W-1:0] pick_seq();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SEQ_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int budget);
    int               first;
    int               kind;
    int               need;
    int               nb;
    logic [LEN_W-1:0] len;
    first = words_sent;
    while (words_sent - first < budget) begin
      kind = $urandom_range(0, 99);
      need = (k_eff > cur_mm) ? k_eff : cur_mm;
      if (kind < 62) begin
        len = clamp_len(longint'(need) + $urandom_range(0, 20));
        nb = (len > 60) ? $urandom_range(20, 60) : int'(len);
        send_segment(len, nb, pick_seq(), 1'b1);
      end else if (kind < 70) begin
        len = LEN_W'($urandom_range(1, 40));
        send_segment(len, int'(len), pick_seq(), 1'b1);
      end else if (kind < 78) begin
        case ($urandom_range(0, 4))
          0: len = LEN_W'(MAX_SEGMENT_LEN);
          1: len = LEN_W'(MAX_SEGMENT_LEN) - 1'b1;
          2: len = LEN_W'(MAX_SEGMENT_LEN) + 1'b1;
          3: len = LEN_ALL_ONES;
          default: len = LEN_W'($urandom_range(1 << 20, 1 << 24));
        endcase
        send_segment(len, $urandom_range(1, 40), pick_seq(), 1'b1);
      end else if (kind < 86) begin
        len = clamp_len(longint'(need) + $urandom_range(0, 6));
        nb = (len > 60) ? 30 : int'(len) + $urandom_range(1, 6);
        send_segment(len, nb, pick_seq(), 1'b1);
      end else if (kind < 93) begin
        send_segment(cur_len, $urandom_range(1, 5), cur_seq, 1'b0);
      end else begin
        nb = $urandom_range(1, 6);
        for (int j = 0; j < nb; j++)
          send_word(2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0),
                    LEN_W'($urandom), SEQ_W'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    logic [K_W-1:0]    k;
    logic [LEN_W-1:0]  mm;
    logic [NSEQ_W-1:0] nseq;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_base = '0;
    in_segment_start = 1'b0;
    in_segment_length = '0;
    in_seq_number = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    apply_setting(6'd2, 25'd2, 21'd5);
    burst_left = 1000;
    // stream from reset without a start mark
    send_word(2'd0, 1'b0, 25'd4, 20'd3);
    send_word(2'd1, 1'b0, 25'd4, 20'd3);
    send_word(2'd2, 1'b0, 25'd4, 20'd3);
    send_word(2'd3, 1'b0, 25'd4, 20'd3);
    // bases past the segment length
    send_word(2'd3, 1'b1, 25'd3, 20'd0);
    send_word(2'd2, 1'b0, 25'd3, 20'd0);
    send_word(2'd1, 1'b0, 25'd3, 20'd0);
    send_word(2'd0, 1'b0, 25'd3, 20'd0);
    send_word(2'd1, 1'b0, 25'd3, 20'd0);
    // short segment, shorter than both k and the minimum match
    send_word(2'd2, 1'b1, 25'd1, 20'hFFFFF);
    // overlong segments
    send_word(2'd1, 1'b1, LEN_ALL_ONES, 20'd7);
    send_word(2'd3, 1'b0, LEN_ALL_ONES, 20'd7);
    send_word(2'd0, 1'b1, LEN_W'(MAX_SEGMENT_LEN) + 1'b1, 20'd9);
    send_word(2'd2, 1'b0, LEN_W'(MAX_SEGMENT_LEN) + 1'b1, 20'd9);
    // longest legal segment, mirrored number wraps
    send_word(2'd3, 1'b1, LEN_W'(MAX_SEGMENT_LEN), 20'hFFFFF);
    send_word(2'd3, 1'b0, LEN_W'(MAX_SEGMENT_LEN), 20'hFFFFF);
    send_word(2'd0, 1'b0, LEN_W'(MAX_SEGMENT_LEN), 20'hFFFFF);
    burst_left = 0;
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      k = K_W'($urandom_range(1, 32));
      nseq = NSEQ_W'($urandom_range(1, (1 << 21) - 1));
      mm = LEN_W'($urandom_range(1, int'(k) + 10));
      case (ph)
        0: begin k = 6'd1; mm = 25'd1; nseq = 21'd1; end
        1: begin k = 6'd32; mm = 25'd32; nseq = 21'h100000; end
        2: begin k = 6'd63; mm = 25'd0; nseq = 21'h1FFFFF; end
        3: begin k = 6'd0; mm = 25'd1; nseq = 21'd0; end
        4: mm = LEN_W'(MAX_SEGMENT_LEN);
        5: mm = LEN_ALL_ONES;
        default: ;
      endcase
      apply_setting(k, mm, nseq);
      if (ph == 2 || ph == 7) hold_req = 1'b1;
      run_phase((ph < 4) ? 220 : (ph == 4) ? 60 : (ph == 5) ? 40 : 130);
    end

    repeat (20) @(posedge clk);
    $display("Scanned %0d bases under %0d register settings, %0d long receiver hold-offs.",
             words_sent, settings_used, holds_done);
    $display("Checked %0d result words: %0d forward, %0d reverse complement.",
             sb.words_checked, sb.fwd_words, sb.rc_words);
    if (sb.pending() != 0)
      sb.report_mismatch("words never delivered", 64'(sb.pending()), 64'd0);
    if (sb.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/kcs_pkg.sv
sv/kcs_kmer_core.sv
sv/kcs_result_fifo.sv
sv/kmer_code_scanner_unit.sv
sv/kcs_checker.sv
tb/tb_kmer_code_scanner_unit.sv
